>>> hw/rtl/tlsi_pkg.sv
// Package for the text line start indexer.
// Holds the record types, character codes and register reset value.
// No dependencies.
`timescale 1ns / 1ps

package tlsi_pkg;

  localparam int REC_COUNT_MAX = 3;

  // Character codes that end a line
  localparam logic [20:0] CP_LF  = 21'h00000A;
  localparam logic [20:0] CP_VT  = 21'h00000B;
  localparam logic [20:0] CP_FF  = 21'h00000C;
  localparam logic [20:0] CP_CR  = 21'h00000D;
  localparam logic [20:0] CP_NEL = 21'h000085;
  localparam logic [20:0] CP_LS  = 21'h002028;
  localparam logic [20:0] CP_PS  = 21'h002029;

  localparam logic [15:0] MAX_LINE_CHARS_RST = 16'd128;

  // One output record
  typedef struct packed {
    logic        last_result;
    logic        end_marker;
    logic [23:0] start_char;
    logic [23:0] start_byte;
    logic [23:0] line_number;
  } rec_t;

  // Records produced by one input transaction, slot 0 goes out first
  typedef struct packed {
    logic [1:0]       count;
    rec_t [2:0]       rec;
  } load_t;

endpackage

>>> hw/rtl/text_line_start_indexer.sv
// Text line start indexer: one decoded character per cycle in, line start records out.
// A record appears at the output in the cycle after the character transaction that causes it.
// Throughput is one character per cycle while out_tready holds; a character causing two or
// three records (last character of a document) holds off the next character while the queue
// drains, and also while out_tready is low.
// Reset is synchronous, active low: counters and queue clear, max_line_chars returns to 128.
// Depends on tlsi_pkg, tlsi_core and tlsi_outq.
`timescale 1ns / 1ps

module text_line_start_indexer #(
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // code_point[20:0], byte_len[23:21]
  input  logic        in_tlast,    // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // line_number[23:0], start_byte[47:24], start_char[71:48]
  output logic        out_tuser,   // end_marker
  output logic        out_tlast,   // last_result
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tlsi_pkg::*;

  logic  accept;
  load_t ld;
  rec_t  head;

  assign accept = in_tvalid && in_tready;

  tlsi_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .code_point  (in_tdata[20:0]),
    .byte_len    (in_tdata[23:21]),
    .last        (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ld          (ld)
  );

  tlsi_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .ld         (ld),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .head       (head),
    .can_load   (in_tready)
  );

  // Output packing
  assign out_tdata = {head.start_char, head.start_byte, head.line_number};
  assign out_tuser = head.end_marker;
  assign out_tlast = head.last_result;

endmodule

>>> hw/rtl/tlsi_core.sv
// Line tracking core: position counters, line end detection and record build.
// Depends on tlsi_pkg.
`timescale 1ns / 1ps

module tlsi_core #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [20:0]         code_point,
  input  logic [2:0]          byte_len,
  input  logic                last,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output tlsi_pkg::load_t     ld
);
  import tlsi_pkg::*;

  localparam int W  = OFFSET_BITS;
  localparam int CW = (W > 16) ? W : 16;

  logic [W-1:0] byte_pos_r, byte_pos_nxt;
  logic [W-1:0] char_pos_r, char_pos_nxt;
  logic [W-1:0] line_byte_r, line_byte_nxt;
  logic [W-1:0] line_char_r, line_char_nxt;
  logic [W-1:0] lines_r, lines_nxt;
  logic         after_cr_r, after_cr_nxt;
  logic [15:0]  max_chars_r;

  logic [W:0]   byte_sum, char_sum, lines_sum1, lines_sum2;
  logic [W-1:0] byte_new, char_new, lines1, lines2, line_byte1, line_char1;
  logic [W-1:0] line_len;
  logic         is_cr, is_term, crlf, forced, close;
  rec_t         rec_close, rec_final, rec_end;

  // Saturating position updates
  always_comb begin
    byte_sum = {1'b0, byte_pos_r} + {{(W-2){1'b0}}, byte_len};
    byte_new = byte_sum[W] ? {W{1'b1}} : byte_sum[W-1:0];
    char_sum = {1'b0, char_pos_r} + (W+1)'(1);
    char_new = char_sum[W] ? {W{1'b1}} : char_sum[W-1:0];
  end

  // Line end classification
  always_comb begin
    is_cr    = (code_point == CP_CR);
    is_term  = (code_point == CP_LF) || (code_point == CP_VT) || (code_point == CP_FF) ||
               (code_point == CP_NEL) || (code_point == CP_LS) || (code_point == CP_PS);
    crlf     = after_cr_r && (code_point == CP_LF);
    line_len = char_new - line_char_r;
    forced   = CW'(line_len) > CW'(max_chars_r);
    close    = !crlf && (is_cr || is_term || forced);
  end

  // Line bookkeeping after this character
  always_comb begin
    lines_sum1 = {1'b0, lines_r} + (W+1)'(1);
    lines1     = close ? (lines_sum1[W] ? {W{1'b1}} : lines_sum1[W-1:0]) : lines_r;
    lines_sum2 = {1'b0, lines1} + (W+1)'(1);
    lines2     = lines_sum2[W] ? {W{1'b1}} : lines_sum2[W-1:0];
    line_byte1 = (close || crlf) ? byte_new : line_byte_r;
    line_char1 = (close || crlf) ? char_new : line_char_r;
  end

  // Record build
  always_comb begin
    rec_close = '{last_result: !last, end_marker: 1'b0, start_char: 24'(line_char_r),
                  start_byte: 24'(line_byte_r), line_number: 24'(lines_r)};
    rec_final = '{last_result: 1'b0, end_marker: 1'b0, start_char: 24'(line_char1),
                  start_byte: 24'(line_byte1), line_number: 24'(lines1)};
    rec_end   = '{last_result: 1'b1, end_marker: 1'b1, start_char: 24'(char_new),
                  start_byte: 24'(byte_new), line_number: 24'(lines2)};
    ld.rec   = '{rec_end, rec_end, rec_close};
    ld.count = 2'd0;
    if (last) begin
      if (close) begin
        ld.rec   = '{rec_end, rec_final, rec_close};
        ld.count = 2'd3;
      end else begin
        ld.rec   = '{rec_end, rec_end, rec_final};
        ld.count = 2'd2;
      end
    end else if (close) begin
      ld.count = 2'd1;
    end
  end

  // Next state: end of document returns everything to zero
  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    char_pos_nxt  = char_pos_r;
    line_byte_nxt = line_byte_r;
    line_char_nxt = line_char_r;
    lines_nxt     = lines_r;
    after_cr_nxt  = after_cr_r;
    if (accept) begin
      if (last) begin
        byte_pos_nxt  = '0;
        char_pos_nxt  = '0;
        line_byte_nxt = '0;
        line_char_nxt = '0;
        lines_nxt     = '0;
        after_cr_nxt  = 1'b0;
      end else begin
        byte_pos_nxt  = byte_new;
        char_pos_nxt  = char_new;
        line_byte_nxt = line_byte1;
        line_char_nxt = line_char1;
        lines_nxt     = lines1;
        after_cr_nxt  = is_cr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      char_pos_r  <= '0;
      line_byte_r <= '0;
      line_char_r <= '0;
      lines_r     <= '0;
      after_cr_r  <= 1'b0;
      max_chars_r <= MAX_LINE_CHARS_RST;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      char_pos_r  <= char_pos_nxt;
      line_byte_r <= line_byte_nxt;
      line_char_r <= line_char_nxt;
      lines_r     <= lines_nxt;
      after_cr_r  <= after_cr_nxt;
      if (cfg_wr_en) begin
        max_chars_r <= cfg_wr_data;
      end
    end
  end

endmodule

>>> hw/rtl/tlsi_outq.sv
// Three-slot record queue that serializes the records of one transaction.
// Depends on tlsi_pkg.
`timescale 1ns / 1ps

module tlsi_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  tlsi_pkg::load_t ld,
  input  logic            out_tready,
  output logic            out_tvalid,
  output tlsi_pkg::rec_t  head,
  output logic            can_load
);
  import tlsi_pkg::*;

  rec_t       rec_r   [REC_COUNT_MAX];
  rec_t       rec_nxt [REC_COUNT_MAX];
  logic [1:0] rem_r, rem_nxt;
  logic       pop;

  assign out_tvalid = (rem_r != 2'd0);
  assign head       = rec_r[0];
  assign pop        = out_tvalid && out_tready;
  // Free when empty, or once the last pending record leaves this cycle
  assign can_load   = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_tready);

  // Load a new set, or shift toward slot 0 on each pop
  always_comb begin
    rec_nxt = rec_r;
    rem_nxt = rem_r;
    if (load) begin
      rec_nxt[0] = ld.rec[0];
      rec_nxt[1] = ld.rec[1];
      rec_nxt[2] = ld.rec[2];
      rem_nxt    = ld.count;
    end else if (pop) begin
      rec_nxt[0] = rec_r[1];
      rec_nxt[1] = rec_r[2];
      rem_nxt    = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

>>> hw/rtl/tlsi_checker.sv
// Port-level checks for the text line start indexer, bound to the top level.
// Depends on text_line_start_indexer port names only.
`timescale 1ns / 1ps

module tlsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // End marker always closes the records of its transaction
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end marker without last_result");

  // Input only stalls while records are pending
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // Stalled output record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) &&
    $stable(out_tlast))
    else $error("stalled output record changed");

endmodule

bind text_line_start_indexer tlsi_checker u_tlsi_checker (.*);
